>>> design/h2r_pkg.sv
// Shared constants and types for the HSV to RGB converter.
// No dependencies; every other design file refers to this package.
package h2r_pkg;

  // Default number of fraction bits; 1.0 is 2**FRAC_BITS
  localparam int FRAC_BITS_DEF = 16;

  // Hue sector, integer part of hue*6. Sector 6 (hue of one) takes the
  // sector zero rule through the default arm of the selector.
  typedef enum logic [2:0] {
    SEC_0 = 3'd0,
    SEC_1 = 3'd1,
    SEC_2 = 3'd2,
    SEC_3 = 3'd3,
    SEC_4 = 3'd4,
    SEC_5 = 3'd5
  } sector_t;

endpackage

>>> design/h2r_prep.sv
// Stage 1: clamp inputs to one, split hue*6 into sector and fraction.
// Depends on h2r_pkg.
module h2r_prep #(
  parameter int FRAC_BITS = h2r_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 vld_i,
  output logic                 rdy_o,
  input  logic [FRAC_BITS:0]   hue_i,
  input  logic [FRAC_BITS:0]   sat_i,
  input  logic [FRAC_BITS:0]   val_i,
  input  logic [FRAC_BITS:0]   alpha_i,
  output logic                 vld_o,
  input  logic                 rdy_i,
  output logic                 grey_o,
  output logic [2:0]           sec_o,
  output logic [FRAC_BITS-1:0] frac_o,
  output logic [FRAC_BITS:0]   sat_o,
  output logic [FRAC_BITS:0]   val_o,
  output logic [FRAC_BITS:0]   alpha_o
);

  localparam int W = FRAC_BITS + 1;
  localparam logic [W-1:0] ONE = W'(1) << FRAC_BITS;

  logic                 vld_r;
  logic                 grey_r, grey_nxt;
  logic [2:0]           sec_r, sec_nxt;
  logic [FRAC_BITS-1:0] frac_r, frac_nxt;
  logic [W-1:0]         sat_r, sat_nxt;
  logic [W-1:0]         val_r, val_nxt;
  logic [W-1:0]         alpha_r, alpha_nxt;
  logic [W-1:0]         hue_c;
  logic [W+1:0]         hue6;

  // clamp and hue*6 as shift-add
  always_comb begin
    hue_c     = (hue_i > ONE) ? ONE : hue_i;
    sat_nxt   = (sat_i > ONE) ? ONE : sat_i;
    val_nxt   = (val_i > ONE) ? ONE : val_i;
    alpha_nxt = (alpha_i > ONE) ? ONE : alpha_i;
    hue6      = {hue_c, 2'b00} + {1'b0, hue_c, 1'b0};
    sec_nxt   = hue6[W+1:FRAC_BITS];
    frac_nxt  = hue6[FRAC_BITS-1:0];
    grey_nxt  = (sat_nxt == '0);
  end

  assign rdy_o = !vld_r || rdy_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy_o) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && vld_i) begin
      grey_r  <= grey_nxt;
      sec_r   <= sec_nxt;
      frac_r  <= frac_nxt;
      sat_r   <= sat_nxt;
      val_r   <= val_nxt;
      alpha_r <= alpha_nxt;
    end
  end

  assign vld_o   = vld_r;
  assign grey_o  = grey_r;
  assign sec_o   = sec_r;
  assign frac_o  = frac_r;
  assign sat_o   = sat_r;
  assign val_o   = val_r;
  assign alpha_o = alpha_r;

endmodule

>>> design/h2r_coef.sv
// Stage 2: scale factors 1-s, 1-s*f and 1-s*(1-f).
// Depends on h2r_pkg.
module h2r_coef #(
  parameter int FRAC_BITS = h2r_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 vld_i,
  output logic                 rdy_o,
  input  logic                 grey_i,
  input  logic [2:0]           sec_i,
  input  logic [FRAC_BITS-1:0] frac_i,
  input  logic [FRAC_BITS:0]   sat_i,
  input  logic [FRAC_BITS:0]   val_i,
  input  logic [FRAC_BITS:0]   alpha_i,
  output logic                 vld_o,
  input  logic                 rdy_i,
  output logic                 grey_o,
  output logic [2:0]           sec_o,
  output logic [FRAC_BITS:0]   kp_o,
  output logic [FRAC_BITS:0]   kq_o,
  output logic [FRAC_BITS:0]   kt_o,
  output logic [FRAC_BITS:0]   val_o,
  output logic [FRAC_BITS:0]   alpha_o
);

  localparam int W  = FRAC_BITS + 1;
  localparam int PW = W + FRAC_BITS;
  localparam logic [W-1:0] ONE = W'(1) << FRAC_BITS;

  logic         vld_r;
  logic         grey_r;
  logic [2:0]   sec_r;
  logic [W-1:0] kp_r, kp_nxt;
  logic [W-1:0] kq_r, kq_nxt;
  logic [W-1:0] kt_r, kt_nxt;
  logic [W-1:0] val_r;
  logic [W-1:0] alpha_r;
  logic [W-1:0] omf;
  logic [PW-1:0] sf_full;
  logic [PW:0]   st_full;

  // two parallel products, truncated, then subtracted from one
  always_comb begin
    omf     = ONE - {1'b0, frac_i};
    sf_full = PW'(sat_i) * PW'(frac_i);
    st_full = (PW + 1)'(sat_i) * (PW + 1)'(omf);
    kp_nxt  = ONE - sat_i;
    kq_nxt  = ONE - sf_full[PW-1:FRAC_BITS];
    kt_nxt  = ONE - st_full[PW-1:FRAC_BITS];
  end

  assign rdy_o = !vld_r || rdy_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy_o) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && vld_i) begin
      grey_r  <= grey_i;
      sec_r   <= sec_i;
      kp_r    <= kp_nxt;
      kq_r    <= kq_nxt;
      kt_r    <= kt_nxt;
      val_r   <= val_i;
      alpha_r <= alpha_i;
    end
  end

  assign vld_o   = vld_r;
  assign grey_o  = grey_r;
  assign sec_o   = sec_r;
  assign kp_o    = kp_r;
  assign kq_o    = kq_r;
  assign kt_o    = kt_r;
  assign val_o   = val_r;
  assign alpha_o = alpha_r;

endmodule

>>> design/h2r_scale.sv
// Stage 3: channel levels p, q and t, each v times its factor.
// Depends on h2r_pkg.
module h2r_scale #(
  parameter int FRAC_BITS = h2r_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               vld_i,
  output logic               rdy_o,
  input  logic               grey_i,
  input  logic [2:0]         sec_i,
  input  logic [FRAC_BITS:0] kp_i,
  input  logic [FRAC_BITS:0] kq_i,
  input  logic [FRAC_BITS:0] kt_i,
  input  logic [FRAC_BITS:0] val_i,
  input  logic [FRAC_BITS:0] alpha_i,
  output logic               vld_o,
  input  logic               rdy_i,
  output logic               grey_o,
  output logic [2:0]         sec_o,
  output logic [FRAC_BITS:0] p_o,
  output logic [FRAC_BITS:0] q_o,
  output logic [FRAC_BITS:0] t_o,
  output logic [FRAC_BITS:0] val_o,
  output logic [FRAC_BITS:0] alpha_o
);

  localparam int W  = FRAC_BITS + 1;
  localparam int PW = 2 * W;

  logic          vld_r;
  logic          grey_r;
  logic [2:0]    sec_r;
  logic [W-1:0]  p_r, q_r, t_r;
  logic [W-1:0]  val_r;
  logic [W-1:0]  alpha_r;
  logic [PW-1:0] p_full, q_full, t_full;

  // three parallel products; v*k never exceeds one so W bits hold it
  always_comb begin
    p_full = PW'(val_i) * PW'(kp_i);
    q_full = PW'(val_i) * PW'(kq_i);
    t_full = PW'(val_i) * PW'(kt_i);
  end

  assign rdy_o = !vld_r || rdy_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy_o) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && vld_i) begin
      grey_r  <= grey_i;
      sec_r   <= sec_i;
      p_r     <= p_full[FRAC_BITS+W-1:FRAC_BITS];
      q_r     <= q_full[FRAC_BITS+W-1:FRAC_BITS];
      t_r     <= t_full[FRAC_BITS+W-1:FRAC_BITS];
      val_r   <= val_i;
      alpha_r <= alpha_i;
    end
  end

  assign vld_o   = vld_r;
  assign grey_o  = grey_r;
  assign sec_o   = sec_r;
  assign p_o     = p_r;
  assign q_o     = q_r;
  assign t_o     = t_r;
  assign val_o   = val_r;
  assign alpha_o = alpha_r;

endmodule

>>> design/h2r_select.sv
// Stage 4: per-sector channel routing into the output register.
// Depends on h2r_pkg (sector codes).
module h2r_select #(
  parameter int FRAC_BITS = h2r_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               vld_i,
  output logic               rdy_o,
  input  logic               grey_i,
  input  logic [2:0]         sec_i,
  input  logic [FRAC_BITS:0] p_i,
  input  logic [FRAC_BITS:0] q_i,
  input  logic [FRAC_BITS:0] t_i,
  input  logic [FRAC_BITS:0] val_i,
  input  logic [FRAC_BITS:0] alpha_i,
  output logic               vld_o,
  input  logic               rdy_i,
  output logic [FRAC_BITS:0] red_o,
  output logic [FRAC_BITS:0] green_o,
  output logic [FRAC_BITS:0] blue_o,
  output logic [FRAC_BITS:0] alpha_o
);

  localparam int W = FRAC_BITS + 1;

  logic         vld_r;
  logic [W-1:0] red_r, red_nxt;
  logic [W-1:0] green_r, green_nxt;
  logic [W-1:0] blue_r, blue_nxt;
  logic [W-1:0] alpha_r;

  // sector routing; grey words take v on all three channels
  always_comb begin
    red_nxt   = val_i;
    green_nxt = val_i;
    blue_nxt  = val_i;
    if (!grey_i) begin
      case (h2r_pkg::sector_t'(sec_i))
        h2r_pkg::SEC_1: begin
          red_nxt  = q_i;
          blue_nxt = p_i;
        end
        h2r_pkg::SEC_2: begin
          red_nxt  = p_i;
          blue_nxt = t_i;
        end
        h2r_pkg::SEC_3: begin
          red_nxt   = p_i;
          green_nxt = q_i;
        end
        h2r_pkg::SEC_4: begin
          red_nxt   = t_i;
          green_nxt = p_i;
        end
        h2r_pkg::SEC_5: begin
          green_nxt = p_i;
          blue_nxt  = q_i;
        end
        // sector zero, and hue of exactly one
        default: begin
          green_nxt = t_i;
          blue_nxt  = p_i;
        end
      endcase
    end
  end

  assign rdy_o = !vld_r || rdy_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy_o) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && vld_i) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
      alpha_r <= alpha_i;
    end
  end

  assign vld_o   = vld_r;
  assign red_o   = red_r;
  assign green_o = green_r;
  assign blue_o  = blue_r;
  assign alpha_o = alpha_r;

endmodule

>>> design/hsv_to_rgb_converter.sv
// Channel   Direction  Handshake          Word
// in_       input      in_valid/in_stall  hue, saturation, brightness, opacity
// out_      output     out_valid/out_stall red, green, blue, opacity_out
//
// Four register stages: clamp and hue split, factor products, level products,
// sector routing into the output register. One word per cycle while out_stall
// is low; out_valid rises once a word has passed through all four register
// stages in order.
// Reset (rst_n low, synchronous) empties the pipeline.
// Each stage holds its word while the next is full and stalled, so bubbles
// close up and in_stall rises only when all four stages are full.
// Depends on h2r_pkg and the h2r_* stage modules.
module hsv_to_rgb_converter #(
  parameter int FRAC_BITS = h2r_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [FRAC_BITS:0] in_hue,
  input  logic [FRAC_BITS:0] in_saturation,
  input  logic [FRAC_BITS:0] in_brightness,
  input  logic [FRAC_BITS:0] in_opacity,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [FRAC_BITS:0] out_red,
  output logic [FRAC_BITS:0] out_green,
  output logic [FRAC_BITS:0] out_blue,
  output logic [FRAC_BITS:0] out_opacity_out
);

  logic                 s1_rdy, s2_rdy, s3_rdy, s4_rdy;
  logic                 s1_vld, s2_vld, s3_vld;
  logic                 s1_grey, s2_grey, s3_grey;
  logic [2:0]           s1_sec, s2_sec, s3_sec;
  logic [FRAC_BITS-1:0] s1_frac;
  logic [FRAC_BITS:0]   s1_sat, s1_val, s1_alpha;
  logic [FRAC_BITS:0]   s2_kp, s2_kq, s2_kt, s2_val, s2_alpha;
  logic [FRAC_BITS:0]   s3_p, s3_q, s3_t, s3_val, s3_alpha;

  assign in_stall = !s1_rdy;

  h2r_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_i   (in_valid),
    .rdy_o   (s1_rdy),
    .hue_i   (in_hue),
    .sat_i   (in_saturation),
    .val_i   (in_brightness),
    .alpha_i (in_opacity),
    .vld_o   (s1_vld),
    .rdy_i   (s2_rdy),
    .grey_o  (s1_grey),
    .sec_o   (s1_sec),
    .frac_o  (s1_frac),
    .sat_o   (s1_sat),
    .val_o   (s1_val),
    .alpha_o (s1_alpha)
  );

  h2r_coef #(.FRAC_BITS(FRAC_BITS)) u_coef (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_i   (s1_vld),
    .rdy_o   (s2_rdy),
    .grey_i  (s1_grey),
    .sec_i   (s1_sec),
    .frac_i  (s1_frac),
    .sat_i   (s1_sat),
    .val_i   (s1_val),
    .alpha_i (s1_alpha),
    .vld_o   (s2_vld),
    .rdy_i   (s3_rdy),
    .grey_o  (s2_grey),
    .sec_o   (s2_sec),
    .kp_o    (s2_kp),
    .kq_o    (s2_kq),
    .kt_o    (s2_kt),
    .val_o   (s2_val),
    .alpha_o (s2_alpha)
  );

  h2r_scale #(.FRAC_BITS(FRAC_BITS)) u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_i   (s2_vld),
    .rdy_o   (s3_rdy),
    .grey_i  (s2_grey),
    .sec_i   (s2_sec),
    .kp_i    (s2_kp),
    .kq_i    (s2_kq),
    .kt_i    (s2_kt),
    .val_i   (s2_val),
    .alpha_i (s2_alpha),
    .vld_o   (s3_vld),
    .rdy_i   (s4_rdy),
    .grey_o  (s3_grey),
    .sec_o   (s3_sec),
    .p_o     (s3_p),
    .q_o     (s3_q),
    .t_o     (s3_t),
    .val_o   (s3_val),
    .alpha_o (s3_alpha)
  );

  h2r_select #(.FRAC_BITS(FRAC_BITS)) u_select (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_i   (s3_vld),
    .rdy_o   (s4_rdy),
    .grey_i  (s3_grey),
    .sec_i   (s3_sec),
    .p_i     (s3_p),
    .q_i     (s3_q),
    .t_i     (s3_t),
    .val_i   (s3_val),
    .alpha_i (s3_alpha),
    .vld_o   (out_valid),
    .rdy_i   (!out_stall),
    .red_o   (out_red),
    .green_o (out_green),
    .blue_o  (out_blue),
    .alpha_o (out_opacity_out)
  );

endmodule

>>> design/h2r_checker.sv
// Port-level checks for the HSV to RGB converter, bound to the top level.
// Depends on h2r_pkg for the default fraction width.
module h2r_checker #(
  parameter int FRAC_BITS = h2r_pkg::FRAC_BITS_DEF
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic [FRAC_BITS:0] in_hue,
  input logic [FRAC_BITS:0] in_saturation,
  input logic [FRAC_BITS:0] in_brightness,
  input logic [FRAC_BITS:0] in_opacity,
  input logic               out_valid,
  input logic               out_stall,
  input logic [FRAC_BITS:0] out_red,
  input logic [FRAC_BITS:0] out_green,
  input logic [FRAC_BITS:0] out_blue,
  input logic [FRAC_BITS:0] out_opacity_out
);

  localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;

  // a stalled input word stays put
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_hue) && $stable(in_saturation)
      && $stable(in_brightness) && $stable(in_opacity))
    else $error("stalled input word changed");

  // a stalled output word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_red) && $stable(out_green)
      && $stable(out_blue) && $stable(out_opacity_out))
    else $error("stalled output word changed");

  // every delivered level stays within one
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_red <= ONE && out_green <= ONE && out_blue <= ONE
      && out_opacity_out <= ONE)
    else $error("output level above one");

  // input blocks only when the output side is full and stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with output free");

  // with no output stall an accepted word reaches the output once it has passed through every stage
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall
      |=> out_valid)
    else $error("accepted word did not reach the output");

endmodule

bind hsv_to_rgb_converter h2r_checker #(.FRAC_BITS(FRAC_BITS)) u_h2r_checker (.*);

>>> verif/tb_hsv_to_rgb_converter.sv
// Testbench for hsv_to_rgb_converter: directed corner words, then random HSV words,
// under random idling on both channels. Every result word is checked against a predictor.
// Depends on h2r_pkg and the converter RTL.
module tb_hsv_to_rgb_converter;

  localparam int          FB         = h2r_pkg::FRAC_BITS_DEF;
  localparam int unsigned ONE        = 1 << FB;
  localparam logic [63:0] ONE_W      = 64'(ONE);
  localparam int          NUM_RANDOM = 1300;
  localparam int          IDLE_LIMIT = 4000;
  localparam int          DRAIN_WAIT = 16;

  typedef struct packed {
    logic [FB:0] hue;
    logic [FB:0] sat;
    logic [FB:0] bright;
    logic [FB:0] opacity;
  } hsv_word_t;

  typedef struct packed {
    logic [FB:0] red;
    logic [FB:0] green;
    logic [FB:0] blue;
    logic [FB:0] opacity;
  } rgb_word_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [FB:0] in_hue = '0;
  logic [FB:0] in_saturation = '0;
  logic [FB:0] in_brightness = '0;
  logic [FB:0] in_opacity = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [FB:0] out_red;
  logic [FB:0] out_green;
  logic [FB:0] out_blue;
  logic [FB:0] out_opacity_out;

  hsv_word_t hsv_pending[$];
  rgb_word_t rgb_expected[$];
  int        err_count = 0;
  int        words_sent = 0;
  int        words_queued = 0;
  int        idle_cycles = 0;

  // Driver and receiver pacing state
  int        tx_gap = 0;
  int        tx_calm_left = 100;
  bit        tx_calm = 1'b0;
  int        rx_stall_left = 0;
  int        rx_calm_left = 150;
  bit        rx_calm = 1'b0;

  hsv_to_rgb_converter #(.FRAC_BITS(FB)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_hue         (in_hue),
    .in_saturation  (in_saturation),
    .in_brightness  (in_brightness),
    .in_opacity     (in_opacity),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_opacity_out(out_opacity_out)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Inputs above 1.0 saturate to 1.0
  function automatic logic [63:0] clamp_unit(logic [FB:0] x);
    return (32'(x) > ONE) ? ONE_W : 64'(x);
  endfunction

  // Fixed-point HSV to RGB, products truncated to FB fraction bits
  function automatic rgb_word_t convert_hsv(hsv_word_t w);
    logic [63:0] h, s, v, a, h6, f, p, q, t;
    rgb_word_t   c;
    h = clamp_unit(w.hue);
    s = clamp_unit(w.sat);
    v = clamp_unit(w.bright);
    a = clamp_unit(w.opacity);
    c.red     = v[FB:0];
    c.green   = v[FB:0];
    c.blue    = v[FB:0];
    c.opacity = a[FB:0];
    if (s != '0) begin
      h6 = h * 64'd6;
      f  = h6 & (ONE_W - 64'd1);
      p  = (v * (ONE_W - s)) >> FB;
      q  = (v * (ONE_W - ((s * f) >> FB))) >> FB;
      t  = (v * (ONE_W - ((s * (ONE_W - f)) >> FB))) >> FB;
      // hue of exactly one lands in sector 6 and takes the sector 0 rule
      case (3'(h6 >> FB))
        h2r_pkg::SEC_1: begin
          c.red  = q[FB:0];
          c.blue = p[FB:0];
        end
        h2r_pkg::SEC_2: begin
          c.red  = p[FB:0];
          c.blue = t[FB:0];
        end
        h2r_pkg::SEC_3: begin
          c.red   = p[FB:0];
          c.green = q[FB:0];
        end
        h2r_pkg::SEC_4: begin
          c.red   = t[FB:0];
          c.green = p[FB:0];
        end
        h2r_pkg::SEC_5: begin
          c.green = p[FB:0];
          c.blue  = q[FB:0];
        end
        default: begin
          c.green = t[FB:0];
          c.blue  = p[FB:0];
        end
      endcase
    end
    return c;
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Random fraction, weighted toward the legal range and its edges;
  // bits above the field width are dropped when the word is queued
  function automatic int unsigned rand_frac();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return $urandom_range(0, ONE);
    if (r < 85) begin
      case ($urandom_range(0, 5))
        0:       return 0;
        1:       return 1;
        2:       return ONE - 1;
        3:       return ONE;
        4:       return ONE + 1;
        default: return '1;
      endcase
    end
    return $urandom;
  endfunction

  task automatic add_hsv(int unsigned h, int unsigned s, int unsigned v, int unsigned a);
    hsv_pending.push_back('{hue: (FB + 1)'(h), sat: (FB + 1)'(s),
                           bright: (FB + 1)'(v), opacity: (FB + 1)'(a)});
    words_queued++;
  endtask

  task automatic report_mismatch(string what, logic [FB:0] got, logic [FB:0] want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    err_count++;
  endtask

  // Driver: holds a stalled word, otherwise loads the next one after its gap
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (tx_calm_left == 0) begin
        tx_calm      = !tx_calm;
        tx_calm_left = $urandom_range(30, 300);
      end else begin
        tx_calm_left--;
      end
      if (in_valid && !in_stall) begin
        rgb_expected.push_back(convert_hsv('{hue: in_hue, sat: in_saturation,
                                             bright: in_brightness, opacity: in_opacity}));
        words_sent++;
        tx_gap = tx_calm ? 0 : pick_gap();
      end
      if (!(in_valid && in_stall)) begin
        if (tx_gap == 0 && hsv_pending.size() != 0) begin
          in_hue        <= hsv_pending[0].hue;
          in_saturation <= hsv_pending[0].sat;
          in_brightness <= hsv_pending[0].bright;
          in_opacity    <= hsv_pending[0].opacity;
          void'(hsv_pending.pop_front());
          in_valid      <= 1'b1;
        end else begin
          in_valid <= 1'b0;
          if (tx_gap > 0) tx_gap--;
        end
      end
    end
  end

  // Monitor: checks each accepted result word and paces out_stall
  always @(posedge clk) begin
    rgb_word_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (rgb_expected.size() == 0) begin
          $display("[%0t] result word with nothing expected", $time);
          err_count++;
        end else begin
          want = rgb_expected.pop_front();
          if (out_red !== want.red) report_mismatch("red", out_red, want.red);
          if (out_green !== want.green) report_mismatch("green", out_green, want.green);
          if (out_blue !== want.blue) report_mismatch("blue", out_blue, want.blue);
          if (out_opacity_out !== want.opacity)
            report_mismatch("opacity_out", out_opacity_out, want.opacity);
        end
      end
      if (rx_calm_left == 0) begin
        rx_calm      = !rx_calm;
        rx_calm_left = $urandom_range(30, 300);
      end else begin
        rx_calm_left--;
      end
      if (rx_stall_left > 0) begin
        rx_stall_left--;
        out_stall <= 1'b1;
      end else if (!rx_calm && $urandom_range(0, 3) == 0) begin
        rx_stall_left = pick_gap();
        out_stall     <= (rx_stall_left > 0);
        if (rx_stall_left > 0) rx_stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int unsigned sat_pick;
    int          sec;

    // Directed: extremes, grey, hue of one, inputs above one, sector edges
    add_hsv(0, 0, 0, 0);
    add_hsv(ONE, ONE, ONE, ONE);
    add_hsv('1, '1, '1, '1);
    add_hsv(ONE + 1, ONE + 1, ONE + 1, ONE + 1);
    add_hsv(ONE, ONE / 2, ONE / 2, ONE / 3);
    add_hsv(12345, 0, 40000, 7);
    add_hsv(ONE, 0, ONE, 0);
    add_hsv(ONE / 2, ONE, 0, ONE);
    add_hsv(1, ONE, ONE, ONE - 1);
    add_hsv(ONE - 1, ONE, ONE, 1);
    add_hsv(ONE - 1, 1, ONE - 1, '1);
    for (sec = 0; sec < 6; sec++) begin
      add_hsv((sec * ONE + ONE / 2) / 6, 50000, 60000, sec * 1000);
      if (sec > 0) begin
        add_hsv((sec * ONE + 5) / 6, ONE, ONE, ONE);
        add_hsv((sec * ONE + 5) / 6 - 1, ONE, ONE, ONE);
      end
    end

    // Random: mostly legal fractions, with edges, grey and out-of-range words
    repeat (NUM_RANDOM) begin
      sat_pick = ($urandom_range(0, 9) == 0) ? 0 : rand_frac();
      add_hsv(rand_frac(), sat_pick, rand_frac(), rand_frac());
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (words_sent < words_queued) @(posedge clk);
    while (rgb_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> files.f
design/h2r_pkg.sv
design/h2r_prep.sv
design/h2r_coef.sv
design/h2r_scale.sv
design/h2r_select.sv
design/hsv_to_rgb_converter.sv
design/h2r_checker.sv
verif/tb_hsv_to_rgb_converter.sv
